[hdl/pm_pkg.sv]
// ----------------------------------------------------------------------------
// pm_pkg
// Shared types and constants of the polynomial multiplier.
// ----------------------------------------------------------------------------
package pm_pkg;

    localparam int MAX_DEGREE   = 31;
    localparam int COEF_BITS    = 16;
    localparam int ADDR_BITS    = $clog2(MAX_DEGREE + 1);
    localparam int DEPTH        = MAX_DEGREE + 1;
    localparam int DEG_BITS     = 5;
    localparam int INDEX_BITS   = 5;
    localparam int VALUE_BITS   = 16;
    localparam int POWER_BITS   = 6;
    localparam int PRODUCT_BITS = 37;
    localparam int MUL_BITS     = 2 * COEF_BITS;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    typedef logic signed [COEF_BITS-1:0]    t_coef;
    typedef logic signed [MUL_BITS-1:0]     t_mul;
    typedef logic signed [PRODUCT_BITS-1:0] t_acc;

    typedef enum logic [1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_RUN    = 2'd2
    } t_cmd;

    typedef enum logic {
        REG_DEGREE_A = 1'b0,
        REG_DEGREE_B = 1'b1
    } t_reg;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    typedef struct packed {
        logic                  first;
        logic                  k_end;
        logic                  run_last;
        logic [POWER_BITS-1:0] k;
    } t_tag;

    typedef struct packed {
        logic                 valid;
        logic [ADDR_BITS-1:0] addr_a;
        logic [ADDR_BITS-1:0] addr_b;
        t_tag                 tag;
    } t_issue;

endpackage

[hdl/pm_seq.sv]
// ----------------------------------------------------------------------------
// pm_seq
// Term sequencer: walks every (i, k-i) pair of the convolution in ascending
// power order, issuing one coefficient pair per cycle while i_advance is high.
// ----------------------------------------------------------------------------
module pm_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_advance,
    input  logic [pm_pkg::DEG_BITS-1:0]  i_degree_a,
    input  logic [pm_pkg::DEG_BITS-1:0]  i_degree_b,
    output logic                         o_busy,
    output pm_pkg::t_issue               o_issue
);

    pm_pkg::t_state                  r_state, n_state;
    logic [pm_pkg::POWER_BITS-1:0]   r_k, n_k;
    logic [pm_pkg::DEG_BITS-1:0]     r_i, n_i;

    logic [pm_pkg::POWER_BITS-1:0]   w_top;
    logic [pm_pkg::POWER_BITS-1:0]   w_deg_a_ext;
    logic [pm_pkg::POWER_BITS-1:0]   w_deg_b_ext;
    logic [pm_pkg::POWER_BITS-1:0]   w_i_ext;
    logic [pm_pkg::POWER_BITS-1:0]   w_j;
    logic [pm_pkg::DEG_BITS-1:0]     w_i_hi;
    logic [pm_pkg::POWER_BITS-1:0]   w_lo_cur_full;
    logic [pm_pkg::DEG_BITS-1:0]     w_lo_cur;
    logic [pm_pkg::POWER_BITS-1:0]   w_k_next;
    logic [pm_pkg::POWER_BITS-1:0]   w_lo_next_full;
    logic [pm_pkg::DEG_BITS-1:0]     w_lo_next;
    logic                            w_k_end;
    logic                            w_run_last;

    assign w_deg_a_ext   = {1'b0, i_degree_a};
    assign w_deg_b_ext   = {1'b0, i_degree_b};
    assign w_i_ext       = {1'b0, r_i};
    assign w_top         = w_deg_a_ext + w_deg_b_ext;
    assign w_j           = r_k - w_i_ext;
    assign w_i_hi        = (r_k < w_deg_a_ext) ? r_k[pm_pkg::DEG_BITS-1:0] : i_degree_a;
    assign w_lo_cur_full = (r_k > w_deg_b_ext) ? (r_k - w_deg_b_ext) : '0;
    assign w_lo_cur      = w_lo_cur_full[pm_pkg::DEG_BITS-1:0];
    assign w_k_next      = r_k + 1'b1;
    assign w_lo_next_full = (w_k_next > w_deg_b_ext) ? (w_k_next - w_deg_b_ext) : '0;
    assign w_lo_next     = w_lo_next_full[pm_pkg::DEG_BITS-1:0];
    assign w_k_end       = (r_i == w_i_hi);
    assign w_run_last    = (r_k == w_top);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pm_pkg::ST_IDLE;
            r_k     <= '0;
            r_i     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_i     <= n_i;
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_i     = r_i;
        case (r_state)
            pm_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = pm_pkg::ST_RUN;
                    n_k     = '0;
                    n_i     = '0;
                end
            end
            pm_pkg::ST_RUN: begin
                if (i_advance) begin
                    if (w_k_end) begin
                        if (w_run_last) begin
                            n_state = pm_pkg::ST_IDLE;
                        end else begin
                            n_k = w_k_next;
                            n_i = w_lo_next;
                        end
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end
            end
            default: begin
                n_state = pm_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy                = (r_state == pm_pkg::ST_RUN);
    assign o_issue.valid         = (r_state == pm_pkg::ST_RUN);
    assign o_issue.addr_a        = r_i[pm_pkg::ADDR_BITS-1:0];
    assign o_issue.addr_b        = w_j[pm_pkg::ADDR_BITS-1:0];
    assign o_issue.tag.first     = (r_i == w_lo_cur);
    assign o_issue.tag.k_end     = w_k_end;
    assign o_issue.tag.run_last  = w_run_last;
    assign o_issue.tag.k         = r_k;

`ifndef SYNTH
    a_i_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pm_pkg::ST_RUN) |-> (r_i <= w_i_hi && r_i >= w_lo_cur))
        else $error("term index outside its power window");

    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pm_pkg::ST_RUN) |-> (r_k <= w_top))
        else $error("power index past the top power");

    a_start_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pm_pkg::ST_IDLE && i_start) |=> (r_k == '0 && r_i == '0))
        else $error("run did not start at power zero");
`endif

endmodule

[hdl/polynomial_multiply.sv]
// ----------------------------------------------------------------------------
// polynomial_multiply
// Integer polynomial multiplier by direct linear convolution.
// ----------------------------------------------------------------------------
// A load transfer writes one coefficient of A or B into its coefficient
// memory. A run transfer produces degree_a+degree_b+1 result transfers in
// ascending power order, last set on the highest power. It holds the input
// stall while its (degree_a+1)*(degree_b+1) product terms are issued, since
// each coefficient memory has one read port and one product term is issued
// per cycle while the output is not stalled. The last result then passes the
// read, multiply and accumulate registers. Input stall is high while a run
// issues terms; an output stall freezes the term pipeline.
module polynomial_multiply (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_cmd,
    input  logic [pm_pkg::INDEX_BITS-1:0]     i_coef_index,
    input  logic signed [pm_pkg::VALUE_BITS-1:0] i_coef_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [pm_pkg::POWER_BITS-1:0]     o_power,
    output logic signed [pm_pkg::PRODUCT_BITS-1:0] o_product_coef,
    output logic                              o_last,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pm_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [pm_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [pm_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                              pready
);

    logic [pm_pkg::DEG_BITS-1:0]     r_degree_a;
    logic [pm_pkg::DEG_BITS-1:0]     r_degree_b;
    logic [pm_pkg::DEG_BITS-1:0]     w_wdeg;
    logic                            w_cfg_wr;

    pm_pkg::t_coef                   r_mem_a [pm_pkg::DEPTH];
    pm_pkg::t_coef                   r_mem_b [pm_pkg::DEPTH];
    pm_pkg::t_coef                   r_rd_a;
    pm_pkg::t_coef                   r_rd_b;

    logic                            w_accept;
    logic                            w_index_ok;
    logic                            w_load_a;
    logic                            w_load_b;
    logic                            w_start;
    logic [pm_pkg::ADDR_BITS-1:0]    w_wr_addr;
    pm_pkg::t_coef                   w_wr_data;

    logic                            w_busy;
    logic                            w_adv;
    pm_pkg::t_issue                  w_issue;

    logic                            r_p1_valid;
    pm_pkg::t_tag                    r_p1_tag;
    logic                            r_p2_valid;
    pm_pkg::t_tag                    r_p2_tag;
    pm_pkg::t_mul                    r_prod;
    pm_pkg::t_acc                    r_acc;
    pm_pkg::t_acc                    w_acc_sum;

    logic                            r_out_valid;
    logic [pm_pkg::POWER_BITS-1:0]   r_out_power;
    pm_pkg::t_acc                    r_out_coef;
    logic                            r_out_last;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_wdeg   = (pwdata[pm_pkg::DEG_BITS-1:0] > pm_pkg::DEG_BITS'(pm_pkg::MAX_DEGREE))
                    ? pm_pkg::DEG_BITS'(pm_pkg::MAX_DEGREE) : pwdata[pm_pkg::DEG_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree_a <= '0;
            r_degree_b <= '0;
        end else if (w_cfg_wr) begin
            case (pm_pkg::t_reg'(paddr[2]))
                pm_pkg::REG_DEGREE_A: r_degree_a <= w_wdeg;
                pm_pkg::REG_DEGREE_B: r_degree_b <= w_wdeg;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (pm_pkg::t_reg'(paddr[2]))
            pm_pkg::REG_DEGREE_A: prdata = pm_pkg::APB_DATA_BITS'(r_degree_a);
            pm_pkg::REG_DEGREE_B: prdata = pm_pkg::APB_DATA_BITS'(r_degree_b);
            default:              prdata = '0;
        endcase
    end

    // input decode
    assign o_stall    = w_busy;
    assign w_accept   = i_valid && !o_stall;
    assign w_index_ok = (i_coef_index <= pm_pkg::INDEX_BITS'(pm_pkg::MAX_DEGREE));
    assign w_wr_addr  = i_coef_index[pm_pkg::ADDR_BITS-1:0];
    assign w_wr_data  = pm_pkg::t_coef'(i_coef_value);

    always_comb begin
        w_load_a = 1'b0;
        w_load_b = 1'b0;
        w_start  = 1'b0;
        case (pm_pkg::t_cmd'(i_cmd))
            pm_pkg::CMD_LOAD_A: w_load_a = w_accept && w_index_ok;
            pm_pkg::CMD_LOAD_B: w_load_b = w_accept && w_index_ok;
            pm_pkg::CMD_RUN:    w_start  = w_accept;
            default: begin
            end
        endcase
    end

    assign w_adv = !r_out_valid || !i_stall;

    pm_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_advance  (w_adv),
        .i_degree_a (r_degree_a),
        .i_degree_b (r_degree_b),
        .o_busy     (w_busy),
        .o_issue    (w_issue)
    );

    // coefficient memories
    always_ff @(posedge i_clk) begin
        if (w_load_a) begin
            r_mem_a[w_wr_addr] <= w_wr_data;
        end
        if (w_adv) begin
            r_rd_a <= r_mem_a[w_issue.addr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_b) begin
            r_mem_b[w_wr_addr] <= w_wr_data;
        end
        if (w_adv) begin
            r_rd_b <= r_mem_b[w_issue.addr_b];
        end
    end

    // term pipeline: read, multiply, accumulate
    assign w_acc_sum = (r_p2_tag.first ? pm_pkg::t_acc'(0) : r_acc)
                     + pm_pkg::t_acc'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_p1_valid  <= w_issue.valid;
            r_p2_valid  <= r_p1_valid;
            r_out_valid <= r_p2_valid && r_p2_tag.k_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p1_tag <= w_issue.tag;
            r_p2_tag <= r_p1_tag;
            r_prod   <= r_rd_a * r_rd_b;
            if (r_p2_valid) begin
                r_acc <= w_acc_sum;
                if (r_p2_tag.k_end) begin
                    r_out_power <= r_p2_tag.k;
                    r_out_coef  <= w_acc_sum;
                    r_out_last  <= r_p2_tag.run_last;
                end
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_power        = r_out_power;
    assign o_product_coef = r_out_coef;
    assign o_last         = r_out_last;

`ifndef SYNTH
    a_run_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_cmd == pm_pkg::CMD_RUN) |=> o_stall)
        else $error("run transfer did not stall the input");

    a_freeze_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_adv) |=> ($stable(r_p1_valid) && $stable(r_p2_valid)))
        else $error("term pipeline moved while output was stalled");

    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_p2_valid && r_p2_tag.k_end) |=> r_out_valid)
        else $error("finished coefficient not presented");
`endif

endmodule
